>>> hw/rtl/ptsor_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsor_pkg
// Shared types and constants of the per-tag sharpness outlier filter.
// ----------------------------------------------------------------------------
package ptsor_pkg;

   // Fixed field widths of the request and response.
   localparam int TAG_BITS       = 10;
   localparam int FOCUS_IN_BITS  = 32;
   localparam int REQ_DATA_BITS  = 48;
   localparam int RSP_DATA_BITS  = 16;
   localparam int RSP_USER_BITS  = 2;

   // Default parameter values.
   localparam int TAG_SLOTS_DEF  = 1024;
   localparam int FOCUS_BITS_DEF = 32;

   // Window geometry and ranks (zero based: 4th and 13th smallest).
   localparam int WIN_LEN   = 16;
   localparam int WIN_BITS  = 4;
   localparam int FILL_BITS = 5;
   localparam int RANK_LOW  = 3;
   localparam int RANK_HIGH = 12;

   // Per-tag bookkeeping held in the metadata memory.
   typedef struct packed {
      logic [FILL_BITS-1:0] fill;
      logic [WIN_BITS-1:0]  oldest;
   } meta_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FOLD,
      ST_LOOKUP,
      ST_UPDATE,
      ST_RANK,
      ST_FENCE,
      ST_DONE
   } state_type;

endpackage

>>> hw/rtl/per_tag_sharpness_outlier_reject_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_tag_sharpness_outlier_reject_top
// Rejects sharpness measures above the upper Tukey fence of each tag's window
// of its last sixteen measures, once that window is full.
// ----------------------------------------------------------------------------
// After reset the block sweeps the per-tag metadata memory clear, one tag per
// cycle, and takes no request until the sweep is done. A request then goes
// through the lookup and update states, and once the tag's window holds
// sixteen measures also through ranking and the fence: the window memory has
// a single read port, so the sixteen entries are read one per cycle and
// inserted into a sorted register row. When TAG_SLOTS is below 1024 the tag is
// first folded onto a slot by a multiplication with the reciprocal of the slot
// count followed by a multiply-subtract. One request is worked on at a time;
// the response register lets the next request in while a response still
// waits to be taken.
module per_tag_sharpness_outlier_reject_top #(
   parameter int TAG_SLOTS  = ptsor_pkg::TAG_SLOTS_DEF,
   parameter int FOCUS_BITS = ptsor_pkg::FOCUS_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [9:0] tag_id, [41:10] focus_value, [47:42] zero
   input  logic [ptsor_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [9:0] tag_echo, [15:10] zero
   output logic [ptsor_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // [0] rejected, [1] window_full
   output logic [ptsor_pkg::RSP_USER_BITS-1:0] rsp_tuser
);
   import ptsor_pkg::*;

   localparam int SLOT_W     = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
   localparam int WADDR_W    = SLOT_W + WIN_BITS;
   localparam int WIN_DEPTH  = TAG_SLOTS * WIN_LEN;
   localparam bit NEED_FOLD  = (TAG_SLOTS < (1 << TAG_BITS));
   localparam int FENCE_W    = FOCUS_BITS + 2;
   localparam int RD_W       = WIN_BITS + 1;
   localparam int FOLD_SHIFT = 2 * TAG_BITS;
   localparam int FOLD_RECIP = ((1 << FOLD_SHIFT) + TAG_SLOTS - 1) / TAG_SLOTS;
   localparam int PROD_W     = TAG_BITS + FOLD_SHIFT + 1;
   localparam int BACK_W     = 2 * TAG_BITS;

   // Storage.
   meta_type              meta_mem [TAG_SLOTS];
   logic [FOCUS_BITS-1:0] win_mem  [WIN_DEPTH];

   // Control registers.
   state_type             state_ff, state_in;
   logic [SLOT_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic                  fold_step_ff, fold_step_in;
   logic [RD_W-1:0]       rd_cnt_ff, rd_cnt_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [TAG_BITS-1:0]   tag_ff;
   logic [TAG_BITS-1:0]   rem_ff, rem_in;
   logic [TAG_BITS-1:0]   quot_ff;
   logic [FOCUS_BITS-1:0] val_ff;
   logic                  full_ff;
   logic [FENCE_W-1:0]    fence_ff;
   logic [FOCUS_BITS-1:0] sorted_ff [WIN_LEN];
   logic [FOCUS_BITS-1:0] sorted_in [WIN_LEN];
   logic [TAG_BITS-1:0]   rsp_tag_ff;
   logic                  rsp_rej_ff;
   logic                  rsp_full_ff;
   meta_type              meta_q_ff;
   logic [FOCUS_BITS-1:0] win_q_ff;

   // Memory controls and datapath nets.
   logic                  accept;
   logic                  out_free;
   logic [SLOT_W-1:0]     slot;
   logic                  meta_we, meta_re;
   logic [SLOT_W-1:0]     meta_waddr;
   meta_type              meta_wdata;
   meta_type              meta_upd;
   logic                  win_we, win_re;
   logic [WADDR_W-1:0]    win_waddr, win_raddr;
   logic [PROD_W-1:0]     fold_prod;
   logic [BACK_W-1:0]     fold_back;
   logic [WIN_LEN-1:0]    gt;
   logic [WIN_LEN-1:0]    gt_prev;
   logic [FOCUS_BITS-1:0] prev_val [WIN_LEN];
   logic [FOCUS_BITS-1:0] diff;
   logic [FENCE_W-1:0]    fence_in;
   logic                  rej;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign slot       = SLOT_W'(rem_ff);

   // Tag fold: the quotient comes from a reciprocal multiplication that is exact
   // for every ten-bit tag, and the remainder from a multiply-subtract in the following cycle.
   assign fold_prod = PROD_W'(rem_ff) * PROD_W'(FOLD_RECIP);
   assign fold_back = BACK_W'(quot_ff) * BACK_W'(TAG_SLOTS);
   always_comb begin
      rem_in = rem_ff;
      if (accept) begin
         rem_in = req_tdata[TAG_BITS-1:0];
      end else if (state_ff == ST_FOLD && fold_step_ff) begin
         rem_in = rem_ff - fold_back[TAG_BITS-1:0];
      end
   end

   // Updated bookkeeping: advance the ring position, saturate the fill.
   always_comb begin
      meta_upd.oldest = meta_q_ff.oldest + WIN_BITS'(1);
      meta_upd.fill   = (meta_q_ff.fill < FILL_BITS'(WIN_LEN)) ?
                        meta_q_ff.fill + FILL_BITS'(1) : meta_q_ff.fill;
   end

   // Sorted insertion row: each entry keeps, takes its left neighbour or the new value.
   assign gt_prev = {gt[WIN_LEN-2:0], 1'b0};
   always_comb begin
      for (int i = 0; i < WIN_LEN; i++) begin
         gt[i] = sorted_ff[i] > win_q_ff;
      end
      prev_val[0] = win_q_ff;
      for (int i = 1; i < WIN_LEN; i++) begin
         prev_val[i] = sorted_ff[i-1];
      end
      for (int i = 0; i < WIN_LEN; i++) begin
         if (!gt[i]) begin
            sorted_in[i] = sorted_ff[i];
         end else if (gt_prev[i]) begin
            sorted_in[i] = prev_val[i];
         end else begin
            sorted_in[i] = win_q_ff;
         end
      end
   end

   // Upper fence v13 + d + d/2, kept two bits wider so it cannot wrap.
   assign diff     = sorted_ff[RANK_HIGH] - sorted_ff[RANK_LOW];
   assign fence_in = FENCE_W'(sorted_ff[RANK_HIGH]) + FENCE_W'(diff)
                   + FENCE_W'(diff >> 1);
   assign rej      = full_ff && (FENCE_W'(val_ff) > fence_ff);

   // Next state and memory controls.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      fold_step_in = fold_step_ff;
      rd_cnt_in    = rd_cnt_ff;
      rd_vld_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      meta_we      = 1'b0;
      meta_re      = 1'b0;
      meta_waddr   = slot;
      meta_wdata   = meta_upd;
      win_we       = 1'b0;
      win_re       = 1'b0;
      win_waddr    = {slot, meta_q_ff.oldest};
      win_raddr    = {slot, rd_cnt_ff[WIN_BITS-1:0]};
      unique case (state_ff)
         ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_cnt_ff;
            meta_wdata = '0;
            clr_cnt_in = clr_cnt_ff + SLOT_W'(1);
            if (clr_cnt_ff == SLOT_W'(TAG_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            fold_step_in = 1'b0;
            if (accept) begin
               state_in = NEED_FOLD ? ST_FOLD : ST_LOOKUP;
            end
         end
         ST_FOLD: begin
            fold_step_in = 1'b1;
            if (fold_step_ff) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            meta_re  = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            meta_we   = 1'b1;
            win_we    = 1'b1;
            rd_cnt_in = '0;
            state_in  = (meta_upd.fill >= FILL_BITS'(WIN_LEN)) ? ST_RANK : ST_DONE;
         end
         ST_RANK: begin
            if (rd_cnt_ff < RD_W'(WIN_LEN)) begin
               win_re    = 1'b1;
               rd_vld_in = 1'b1;
               rd_cnt_in = rd_cnt_ff + RD_W'(1);
            end else if (rd_vld_ff) begin
               state_in = ST_FENCE;
            end
         end
         ST_FENCE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         fold_step_ff <= 1'b0;
         rd_cnt_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         fold_step_ff <= fold_step_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (accept) begin
         tag_ff <= req_tdata[TAG_BITS-1:0];
         val_ff <= FOCUS_BITS'(req_tdata[TAG_BITS +: FOCUS_IN_BITS]);
      end
      if (state_ff == ST_FOLD && !fold_step_ff) begin
         quot_ff <= fold_prod[FOLD_SHIFT +: TAG_BITS];
      end
      if (state_ff == ST_UPDATE) begin
         full_ff <= (meta_upd.fill >= FILL_BITS'(WIN_LEN));
         for (int i = 0; i < WIN_LEN; i++) begin
            sorted_ff[i] <= '1;
         end
      end else if (state_ff == ST_RANK && rd_vld_ff) begin
         sorted_ff <= sorted_in;
      end
      if (state_ff == ST_FENCE) begin
         fence_ff <= fence_in;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_tag_ff  <= tag_ff;
         rsp_rej_ff  <= rej;
         rsp_full_ff <= full_ff;
      end
   end

   // Per-tag metadata memory.
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      if (meta_re) begin
         meta_q_ff <= meta_mem[slot];
      end
   end

   // Window memory: sixteen measures per tag.
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_waddr] <= val_ff;
      end
      if (win_re) begin
         win_q_ff <= win_mem[win_raddr];
      end
   end

   // Response port.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_tag_ff);
   assign rsp_tuser  = {rsp_full_ff, rsp_rej_ff};

endmodule

>>> tb/per_tag_sharpness_outlier_reject_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_tag_sharpness_outlier_reject_top_tb
// Self-checking bench for the per-tag sharpness outlier filter. A scoreboard
// keeps its own copy of every tag's window of sixteen measures and predicts
// the verdict of each request. Requests come from a directed opening and then
// from per-tag measure profiles with outliers and random noise. Both stream
// sides idle in random bursts, and at one point the response side is held off
// for a long stretch.
// ----------------------------------------------------------------------------
module per_tag_sharpness_outlier_reject_top_tb;
   import ptsor_pkg::*;

   // Bench timing and run shape.
   localparam int RESET_CYCLES = 5;
   localparam int QUIET_LIMIT  = 6000;
   localparam int SETTLE_LIMIT = 50;
   localparam int LONG_HOLD    = 200;
   localparam int PHASES       = 4;
   localparam int PHASE_ITEMS  = 395;
   localparam int WORK_TAGS    = 8;
   localparam int TAG_MAX      = (1 << TAG_BITS) - 1;

   localparam logic [FOCUS_IN_BITS-1:0] FOCUS_MAX  = '1;
   localparam logic [FOCUS_IN_BITS-1:0] FLAT_LEVEL = 32'd1000;

   // Bit positions of the verdict flags in rsp_tuser.
   localparam int USER_REJECTED = 0;
   localparam int USER_FULL     = 1;

   // --------------------------------------------------------------------------
   // Verdict predictor and response checker.
   // --------------------------------------------------------------------------
   class outlier_scoreboard;
      typedef struct packed {
         logic [TAG_BITS-1:0] tag;
         logic                rejected;
         logic                full;
      } verdict_type;

      logic [FOCUS_IN_BITS-1:0] window [TAG_SLOTS_DEF][WIN_LEN];
      int unsigned              fill   [TAG_SLOTS_DEF];
      int unsigned              oldest [TAG_SLOTS_DEF];
      verdict_type              pending[$];
      int unsigned              failures;

      task report_mismatch(string what);
         $display("[%0t] MISMATCH: %0s", $realtime, what);
         failures++;
      endtask

      function int outstanding();
         return pending.size();
      endfunction

      // Adds the measure to the tag's window and queues the expected verdict.
      function void note_request(logic [TAG_BITS-1:0] tag,
                                 logic [FOCUS_IN_BITS-1:0] focus);
         logic [FOCUS_IN_BITS-1:0] ranked [WIN_LEN];
         logic [FOCUS_IN_BITS-1:0] entry;
         logic [FOCUS_IN_BITS+1:0] iqr_span;
         logic [FOCUS_IN_BITS+1:0] fence;
         verdict_type              verdict;
         int                       slot;
         int                       i;
         int                       j;

         slot = tag % TAG_SLOTS_DEF;
         window[slot][oldest[slot]] = focus;
         oldest[slot] = (oldest[slot] + 1) % WIN_LEN;
         if (fill[slot] < WIN_LEN) begin
            fill[slot]++;
         end
         verdict.tag      = tag;
         verdict.full     = (fill[slot] == WIN_LEN);
         verdict.rejected = 1'b0;

         // Rank the full window by insertion, then test the upper fence.
         if (verdict.full) begin
            for (i = 0; i < WIN_LEN; i++) begin
               entry = window[slot][i];
               j = i;
               while (j > 0 && ranked[j-1] > entry) begin
                  ranked[j] = ranked[j-1];
                  j--;
               end
               ranked[j] = entry;
            end
            iqr_span = {2'b00, ranked[RANK_HIGH]} - {2'b00, ranked[RANK_LOW]};
            fence    = {2'b00, ranked[RANK_HIGH]} + iqr_span + (iqr_span >> 1);
            verdict.rejected = ({2'b00, focus} > fence);
         end
         pending = {pending, verdict};
      endfunction

      // Compares one accepted response with the oldest expected verdict.
      task check_response(logic [RSP_DATA_BITS-1:0] tdata,
                          logic [RSP_USER_BITS-1:0] tuser);
         verdict_type want;

         if (pending.size() == 0) begin
            report_mismatch($sformatf("response for tag %0d with no request waiting",
                                      tdata[TAG_BITS-1:0]));
         end else begin
            want = pending.pop_front();
            if (tdata[TAG_BITS-1:0] !== want.tag) begin
               report_mismatch($sformatf("tag_echo %0d, expected %0d",
                                         tdata[TAG_BITS-1:0], want.tag));
            end
            if (tuser[USER_REJECTED] !== want.rejected) begin
               report_mismatch($sformatf("tag %0d rejected %b, expected %b", want.tag,
                                         tuser[USER_REJECTED], want.rejected));
            end
            if (tuser[USER_FULL] !== want.full) begin
               report_mismatch($sformatf("tag %0d window_full %b, expected %b", want.tag,
                                         tuser[USER_FULL], want.full));
            end
         end
      endtask
   endclass

   // --------------------------------------------------------------------------
   // Block under test and its stimulus signals.
   // --------------------------------------------------------------------------
   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // [9:0] tag_id, [41:10] focus_value, [47:42] zero
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // [9:0] tag_echo, [15:10] zero
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   // [0] rejected, [1] window_full
   logic [RSP_USER_BITS-1:0] rsp_tuser;

   outlier_scoreboard sb = new();

   // Idling controls shared by the request and response processes.
   logic req_gaps_on   = 1'b0;
   logic rsp_stalls_on = 1'b0;
   logic long_hold_due = 1'b0;
   int   quiet_cycles  = 0;

   // Measure profile of each tag in the working set of a phase.
   logic [TAG_BITS-1:0]      work_tag    [WORK_TAGS];
   logic [FOCUS_IN_BITS-1:0] work_base   [WORK_TAGS];
   logic [FOCUS_IN_BITS-1:0] work_spread [WORK_TAGS];

   per_tag_sharpness_outlier_reject_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Request and response monitor, with a watchdog on accepted transfers.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_request(req_tdata[TAG_BITS-1:0], req_tdata[TAG_BITS +: FOCUS_IN_BITS]);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata, rsp_tuser);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles = quiet_cycles + 1;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, quiet_cycles);
            $display("per_tag_sharpness_outlier_reject_top test failed");
            $finish;
         end
      end
   end

   // Response side: random stall bursts, and one long hold-off on request.
   initial begin
      int hold_left;

      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold_left     = LONG_HOLD - 1;
            rsp_tready   <= 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 9) == 0) begin
            hold_left   = $urandom_range(1, 19) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offers one request, after a random gap when gaps are enabled, and returns
   // at the edge where it is accepted.
   task automatic send_request(input logic [TAG_BITS-1:0] tag,
                               input logic [FOCUS_IN_BITS-1:0] focus);
      int gap;

      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_BITS - TAG_BITS - FOCUS_IN_BITS){1'b0}}, focus, tag};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops offering and waits until every verdict has come back.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Draws a measure around a tag's profile; one in ten lies far above it.
   function automatic logic [FOCUS_IN_BITS-1:0] draw_focus(
      logic [FOCUS_IN_BITS-1:0] base,
      logic [FOCUS_IN_BITS-1:0] spread
   );
      logic [FOCUS_IN_BITS+1:0] level;

      level = {2'b00, base} + (FOCUS_IN_BITS + 2)'($urandom_range(0, spread));
      if ($urandom_range(0, 99) < 10) begin
         level = level + {spread, 2'b00} + (FOCUS_IN_BITS + 2)'($urandom_range(1, 255));
      end
      return (level > {2'b00, FOCUS_MAX}) ? FOCUS_MAX : level[FOCUS_IN_BITS-1:0];
   endfunction

   // Main sequence.
   initial begin
      logic [TAG_BITS-1:0]      tag;
      logic [FOCUS_IN_BITS-1:0] focus;
      int                       phase;
      int                       n;
      int                       k;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Field extremes and alternating bit patterns on fresh tags.
      send_request('0, '0);
      send_request(TAG_BITS'(TAG_MAX), FOCUS_MAX);
      send_request(10'h2AA, 32'hAAAA_AAAA);
      send_request(10'h155, 32'h5555_5555);

      // A flat window never judges until full; with no spread, one step above
      // the level is rejected and the level itself is not.
      for (n = 0; n < WIN_LEN - 1; n++) begin
         send_request(10'd7, FLAT_LEVEL);
      end
      send_request(10'd7, FLAT_LEVEL + 32'd1);
      send_request(10'd7, FLAT_LEVEL);
      drain_results();

      // Random phases over a small working set of tags, so windows fill.
      for (phase = 0; phase < PHASES; phase++) begin
         req_gaps_on   = (phase == 0 || phase == 1);
         rsp_stalls_on = (phase == 0 || phase == 2);
         for (k = 0; k < WORK_TAGS; k++) begin
            work_tag[k] = TAG_BITS'($urandom_range(0, TAG_MAX));
            case ($urandom_range(0, 3))
               0: work_spread[k] = '0;
               1: work_spread[k] = $urandom_range(1, 255);
               2: work_spread[k] = $urandom_range(256, 1 << 20);
               default: work_spread[k] = $urandom_range(1 << 20, 1 << 30);
            endcase
            // Some profiles sit at the top, where the fence passes the largest measure.
            if ($urandom_range(0, 3) == 0) begin
               work_base[k] = FOCUS_MAX - work_spread[k];
            end else begin
               work_base[k] = $urandom_range(0, 32'h3FFF_FFFF);
            end
         end

         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 15) begin
               tag   = TAG_BITS'($urandom_range(0, TAG_MAX));
               focus = $urandom;
            end else begin
               k     = $urandom_range(0, WORK_TAGS - 1);
               tag   = work_tag[k];
               focus = draw_focus(work_base[k], work_spread[k]);
            end
            send_request(tag, focus);
            // Hold the response side off while requests keep coming.
            if (phase == 2 && n == 40) begin
               long_hold_due = 1'b1;
            end
         end
         drain_results();
      end

      repeat (SETTLE_LIMIT) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("per_tag_sharpness_outlier_reject_top test passed");
      end else begin
         $display("per_tag_sharpness_outlier_reject_top test failed");
      end
      $finish;
   end

endmodule
